// ===== hw/rtl/dhwt_pkg.sv =====
package dhwt_pkg;

    // table geometry
    localparam int TABLE_SLOTS = 8191;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam int FIELD_W     = 13;

    // key arithmetic: horner sum of four unsigned bytes in base 17
    localparam int HORNER_BASE = 17;
    localparam int KEY_MAX     = 255 * (1 + HORNER_BASE + HORNER_BASE * HORNER_BASE
                                 + HORNER_BASE * HORNER_BASE * HORNER_BASE);
    localparam int KEY_W       = $clog2(KEY_MAX + 1);
    localparam int PROD_W      = 2 * KEY_W;

    // floor reciprocals, scaled by 2^KEY_W, for the home and step moduli
    localparam longint RECIP_HOME = (longint'(1) << KEY_W) / TABLE_SLOTS;
    localparam longint RECIP_STEP = (longint'(1) << KEY_W) / (TABLE_SLOTS - 1);

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // item modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_INSERTED  = 2'd0;
    localparam logic [1:0] STATUS_FOUND     = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    // classified item handed from front to back
    typedef struct packed {
        logic              mode;
        logic [31:0]       word;
        logic [SLOT_W-1:0] home;
        logic [SLOT_W-1:0] step;
    } dhwt_entry_t;

endpackage

// ===== hw/rtl/dhwt_front.sv =====
module dhwt_front
    import dhwt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        mode,
    input  logic [31:0] word,
    output logic        push,
    output dhwt_entry_t push_data,
    input  logic        q_full
);

    logic               a_v_reg, b_v_reg, c_v_reg;
    logic               a_mode_reg, b_mode_reg, c_mode_reg;
    logic [31:0]        a_word_reg, b_word_reg, c_word_reg;
    logic [KEY_W-1:0]   a_key_reg, b_key_reg, c_key_reg;
    logic [KEY_W-1:0]   b_qh_reg, b_qs_reg;
    logic [KEY_W-1:0]   c_ph_reg, c_ps_reg;
    logic [KEY_W-1:0]   key_c;
    logic [PROD_W-1:0]  prod_qh, prod_qs, prod_ph, prod_ps;
    logic [KEY_W-1:0]   rh_raw, rs_raw, rh, rs;
    logic               adv;

    // whole pipe moves together unless the last stage cannot push
    assign adv       = !(c_v_reg && q_full);
    assign req_ready = adv;

    // horner key, most significant byte first
    always_comb
    begin
        key_c = KEY_W'(word[31:24]);
        for (int i = 2; i >= 0; i--)
        begin
            key_c = KEY_W'(key_c * HORNER_BASE) + KEY_W'(word[8*i +: 8]);
        end
    end

    // quotient estimates by reciprocal multiplication
    assign prod_qh = PROD_W'(a_key_reg) * PROD_W'(RECIP_HOME);
    assign prod_qs = PROD_W'(a_key_reg) * PROD_W'(RECIP_STEP);

    // quotient times modulus
    assign prod_ph = PROD_W'(b_qh_reg) * PROD_W'(TABLE_SLOTS);
    assign prod_ps = PROD_W'(b_qs_reg) * PROD_W'(TABLE_SLOTS - 1);

    // remainders, estimate is at most one short
    always_comb
    begin
        rh_raw = c_key_reg - c_ph_reg;
        rs_raw = c_key_reg - c_ps_reg;
        rh = (rh_raw >= KEY_W'(TABLE_SLOTS)) ? rh_raw - KEY_W'(TABLE_SLOTS) : rh_raw;
        rs = (rs_raw >= KEY_W'(TABLE_SLOTS - 1)) ? rs_raw - KEY_W'(TABLE_SLOTS - 1) : rs_raw;
    end

    assign push           = c_v_reg && !q_full;
    assign push_data.mode = c_mode_reg;
    assign push_data.word = c_word_reg;
    assign push_data.home = rh[SLOT_W-1:0];
    assign push_data.step = rs[SLOT_W-1:0] + SLOT_W'(1);

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg <= req_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_mode_reg <= mode;
            a_word_reg <= word;
            a_key_reg  <= key_c;
            b_mode_reg <= a_mode_reg;
            b_word_reg <= a_word_reg;
            b_key_reg  <= a_key_reg;
            b_qh_reg   <= prod_qh[PROD_W-1:KEY_W];
            b_qs_reg   <= prod_qs[PROD_W-1:KEY_W];
            c_mode_reg <= b_mode_reg;
            c_word_reg <= b_word_reg;
            c_key_reg  <= b_key_reg;
            c_ph_reg   <= prod_ph[KEY_W-1:0];
            c_ps_reg   <= prod_ps[KEY_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/dhwt_queue.sv =====
module dhwt_queue
    import dhwt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  dhwt_entry_t push_data,
    output logic        full,
    input  logic        pop,
    output dhwt_entry_t pop_data,
    output logic        empty
);

    dhwt_entry_t        entries_reg [Q_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entries_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("queue written while full");
    assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
        else $error("queue read while empty");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (push && !pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
        else $error("queue count did not follow a lone write");

endmodule

// ===== hw/rtl/dhwt_back.sv =====
module dhwt_back
    import dhwt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  dhwt_entry_t         pop_data,
    output logic                pop,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [1:0]          status,
    output logic [FIELD_W-1:0]  probe_count,
    output logic [FIELD_W-1:0]  slot_index
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_PROBE = 2'd2;
    localparam logic [1:0] ST_CHECK = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [SLOT_W-1:0]   clr_idx_reg, clr_idx_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [SLOT_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]    probes_reg, probes_next;
    logic                mode_reg, mode_next;
    logic [31:0]         word_reg, word_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [1:0]          status_reg, status_next;
    logic [FIELD_W-1:0]  probe_count_reg, probe_count_next;
    logic [FIELD_W-1:0]  slot_index_reg, slot_index_next;

    logic                valid_mem [TABLE_SLOTS];
    logic [31:0]         word_mem  [TABLE_SLOTS];
    logic                rd_valid_reg;
    logic [31:0]         rd_word_reg;

    logic                mem_we, word_we, mem_wdata;
    logic [SLOT_W-1:0]   mem_waddr;
    logic                slot_empty, slot_match, probe_done, rsp_free;
    logic [SLOT_W:0]     slot_sum;
    logic [1:0]          done_status;

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign probe_count = probe_count_reg;
    assign slot_index  = slot_index_reg;

    // probe decision on the registered read data
    assign slot_empty = !rd_valid_reg;
    assign slot_match = (mode_reg == MODE_LOOKUP) && (rd_word_reg == word_reg);
    assign probe_done = slot_empty || slot_match || (probes_reg == CNT_W'(TABLE_SLOTS));
    assign rsp_free   = !rsp_valid_reg || rsp_ready;
    assign slot_sum   = {1'b0, slot_reg} + {1'b0, step_reg};

    always_comb
    begin
        priority if (slot_empty)
        begin
            done_status = (mode_reg == MODE_LOOKUP) ? STATUS_NOT_FOUND : STATUS_INSERTED;
        end
        else if (slot_match)
        begin
            done_status = STATUS_FOUND;
        end
        else
        begin
            done_status = STATUS_FULL;
        end
    end

    // memory write port: clearing pass or insert
    always_comb
    begin
        mem_we    = 1'b0;
        word_we   = 1'b0;
        mem_wdata = 1'b1;
        mem_waddr = slot_reg;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_wdata = 1'b0;
            mem_waddr = clr_idx_reg;
        end
        else if (state_reg == ST_CHECK && probe_done && rsp_free && slot_empty
                 && mode_reg == MODE_INSERT)
        begin
            mem_we  = 1'b1;
            word_we = 1'b1;
        end
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        clr_idx_next     = clr_idx_reg;
        slot_next        = slot_reg;
        step_next        = step_reg;
        probes_next      = probes_reg;
        mode_next        = mode_reg;
        word_next        = word_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        status_next      = status_reg;
        probe_count_next = probe_count_reg;
        slot_index_next  = slot_index_reg;
        pop              = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + SLOT_W'(1);
                if (clr_idx_reg == SLOT_W'(TABLE_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop         = 1'b1;
                    mode_next   = pop_data.mode;
                    word_next   = pop_data.word;
                    slot_next   = pop_data.home;
                    step_next   = pop_data.step;
                    probes_next = CNT_W'(1);
                    state_next  = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (probe_done)
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_next   = 1'b1;
                        status_next      = done_status;
                        probe_count_next = FIELD_W'(probes_reg);
                        slot_index_next  = FIELD_W'(slot_reg);
                        state_next       = ST_IDLE;
                    end
                end
                else
                begin
                    slot_next   = (slot_sum >= (SLOT_W + 1)'(TABLE_SLOTS))
                                ? SLOT_W'(slot_sum - (SLOT_W + 1)'(TABLE_SLOTS))
                                : slot_sum[SLOT_W-1:0];
                    probes_next = probes_reg + CNT_W'(1);
                    state_next  = ST_PROBE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        slot_reg        <= slot_next;
        step_reg        <= step_next;
        probes_reg      <= probes_next;
        mode_reg        <= mode_next;
        word_reg        <= word_next;
        status_reg      <= status_next;
        probe_count_reg <= probe_count_next;
        slot_index_reg  <= slot_index_next;
    end

    // slot valid memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            valid_mem[mem_waddr] <= mem_wdata;
        end
        rd_valid_reg <= valid_mem[slot_reg];
    end

    // slot word memory, registered read
    always_ff @(posedge clk)
    begin
        if (word_we)
        begin
            word_mem[mem_waddr] <= word_reg;
        end
        rd_word_reg <= word_mem[slot_reg];
    end

    assert property (@(posedge clk) disable iff (!rst_n)
                     pop |-> (state_reg == ST_IDLE && !q_empty))
        else $error("item taken outside idle or from an empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == ST_PROBE || state_reg == ST_CHECK)
                     |-> (slot_reg < SLOT_W'(TABLE_SLOTS) && probes_reg != '0
                          && probes_reg <= CNT_W'(TABLE_SLOTS)))
        else $error("probe slot or probe count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == ST_CHECK && !probe_done)
                     |=> (state_reg == ST_PROBE && probes_reg == $past(probes_reg) + CNT_W'(1)))
        else $error("probe did not advance");
    assert property (@(posedge clk) disable iff (!rst_n)
                     word_we |-> (state_reg == ST_CHECK && rd_valid_reg == 1'b0))
        else $error("word written over an occupied slot");

endmodule

// ===== hw/rtl/double_hash_word_table_core.sv =====
// hash table of four-byte words, open addressing with double hashing
//
// request channel (req_valid / req_ready): mode selects insert (0) or
// lookup (1) of word. response channel (rsp_valid / rsp_ready): status,
// probe_count and slot_index, one response per request, in request order.
//
// a three-stage front computes the horner key, home slot and probe step
// and hands the item to a two-entry queue. the back takes an item from the
// queue when idle and walks the probe path in the slot memories, each probe
// an address state and then a check state on the registered read data; it
// takes the next item only once the response of the last is registered.
//
// after reset the back clears the slot valid memory, one slot a cycle;
// the front still takes requests until its stages and the queue are full.
// a stalled response stays in the output register while the back carries
// on with the next item up to the point of its response.
module double_hash_word_table_core
    import dhwt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic                mode,
    input  logic [31:0]         word,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [1:0]          status,
    output logic [FIELD_W-1:0]  probe_count,
    output logic [FIELD_W-1:0]  slot_index
);

    logic        push, q_full, pop, q_empty;
    dhwt_entry_t push_data, pop_data;

    // classify: key, home slot, probe step
    dhwt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .mode      (mode),
        .word      (word),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    // decoupling queue
    dhwt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    // probe sequencer and slot memories
    dhwt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .pop_data    (pop_data),
        .pop         (pop),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .probe_count (probe_count),
        .slot_index  (slot_index)
    );

endmodule

// ===== test/dhwt_checker.sv =====
module dhwt_checker
    import dhwt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_ready,
    input  logic               mode,
    input  logic [31:0]        word,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  logic [1:0]         status,
    input  logic [FIELD_W-1:0] probe_count,
    input  logic [FIELD_W-1:0] slot_index,
    output int                 mismatch_count,
    output int                 due_count
);

    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] probe_count;
        logic [FIELD_W-1:0] slot_index;
    } table_result_t;

    // shadow copy of the slot memories
    logic [31:0]   shadow_word [TABLE_SLOTS];
    bit            shadow_used [TABLE_SLOTS];

    table_result_t results_due [$];
    int            errors;
    int            rsp_seen;

    assign mismatch_count = errors;

    // walk the double hashing probe path, updating the shadow table on insert
    function automatic table_result_t predict_table_op(input logic op, input logic [31:0] w);
        int unsigned   key;
        int unsigned   pos;
        int unsigned   stride;
        int unsigned   probes;
        int            i;
        table_result_t r;
        key = 0;
        for (i = 3; i >= 0; i--)
        begin
            key = key * HORNER_BASE + w[8*i +: 8];
        end
        pos    = key % TABLE_SLOTS;
        stride = (1 + key % (TABLE_SLOTS - 1)) % TABLE_SLOTS;
        probes = 0;
        r.status = STATUS_FULL;
        while (probes < TABLE_SLOTS)
        begin
            probes++;
            if (!shadow_used[pos])
            begin
                if (op == MODE_INSERT)
                begin
                    shadow_word[pos] = w;
                    shadow_used[pos] = 1'b1;
                    r.status = STATUS_INSERTED;
                end
                else
                begin
                    r.status = STATUS_NOT_FOUND;
                end
                break;
            end
            if (op == MODE_LOOKUP && shadow_word[pos] == w)
            begin
                r.status = STATUS_FOUND;
                break;
            end
            if (probes < TABLE_SLOTS)
            begin
                pos = pos + stride;
                if (pos >= TABLE_SLOTS)
                begin
                    pos = pos - TABLE_SLOTS;
                end
            end
        end
        r.probe_count = probes[FIELD_W-1:0];
        r.slot_index  = pos[FIELD_W-1:0];
        return r;
    endfunction

    // watch both channels: predict on request transfer, compare on response transfer
    always @(posedge clk or negedge rst_n)
    begin
        table_result_t due;
        if (!rst_n)
        begin
            results_due.delete();
            foreach (shadow_used[n])
            begin
                shadow_used[n] = 1'b0;
            end
            errors    = 0;
            rsp_seen  = 0;
            due_count <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                results_due.push_back(predict_table_op(mode, word));
            end
            if (rsp_valid && rsp_ready)
            begin
                if (results_due.size() == 0)
                begin
                    if (errors < 10)
                    begin
                        $display("response %0d with none due: status %0d probes %0d slot %0d",
                                 rsp_seen, status, probe_count, slot_index);
                    end
                    errors++;
                end
                else
                begin
                    due = results_due.pop_front();
                    if (status !== due.status || probe_count !== due.probe_count
                        || slot_index !== due.slot_index)
                    begin
                        if (errors < 10)
                        begin
                            $display("response %0d: expected status %0d probes %0d slot %0d, %s",
                                     rsp_seen, due.status, due.probe_count, due.slot_index,
                                     $sformatf("got status %0d probes %0d slot %0d",
                                               status, probe_count, slot_index));
                        end
                        errors++;
                    end
                end
                rsp_seen++;
            end
            due_count <= results_due.size();
        end
    end

endmodule

// ===== test/tb.sv =====
module tb;
    import dhwt_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int LONG_HOLD   = 400;
    localparam int RANDOM_OPS  = 1400;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    logic               mode      = MODE_INSERT;
    logic [31:0]        word      = 32'h0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    logic [1:0]         status;
    logic [FIELD_W-1:0] probe_count;
    logic [FIELD_W-1:0] slot_index;

    int                 mismatch_count;
    int                 due_count;

    // stimulus side bookkeeping
    bit                 no_idle       = 1'b0;
    bit                 rsp_hold_long = 1'b0;
    logic [31:0]        inserted_q [$];

    double_hash_word_table_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .mode        (mode),
        .word        (word),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .probe_count (probe_count),
        .slot_index  (slot_index)
    );

    dhwt_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .mode           (mode),
        .word           (word),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .status         (status),
        .probe_count    (probe_count),
        .slot_index     (slot_index),
        .mismatch_count (mismatch_count),
        .due_count      (due_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // response side: random stalls, one long hold-off on request
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rsp_hold_long)
            begin
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                rsp_hold_long = 1'b0;
            end
            else if (no_idle || $urandom_range(0, 2) != 0)
            begin
                rsp_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
        end
    end

    // one request transfer, with an optional idle burst in front
    task automatic send_item(input logic op, input logic [31:0] w);
        if (!no_idle && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_valid <= 1'b1;
        mode      <= op;
        word      <= w;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        if (op == MODE_INSERT)
        begin
            inserted_q.push_back(w);
        end
    endtask

    // stop offering and let every response come back
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
        begin
            @(posedge clk);
        end
    endtask

    // a different word, same horner key and probe path if bytes allow
    function automatic logic [31:0] key_twin(input logic [31:0] w);
        logic [31:0] t;
        t = w;
        if (w[7:0] <= 8'd238 && w[15:8] != 8'd0)
        begin
            t[7:0]  = w[7:0] + 8'd17;
            t[15:8] = w[15:8] - 8'd1;
        end
        else if (w[7:0] >= 8'd17 && w[15:8] != 8'd255)
        begin
            t[7:0]  = w[7:0] - 8'd17;
            t[15:8] = w[15:8] + 8'd1;
        end
        else
        begin
            t[31:24] = ~w[31:24];
        end
        return t;
    endfunction

    initial
    begin
        logic [31:0] w;
        int          pick;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, duplicates, shared keys, zero bytes
        send_item(MODE_LOOKUP, 32'h0000_0000);
        send_item(MODE_INSERT, 32'h0000_0000);
        send_item(MODE_INSERT, 32'hFFFF_FFFF);
        send_item(MODE_LOOKUP, 32'h0000_0000);
        send_item(MODE_LOOKUP, 32'hFFFF_FFFF);
        send_item(MODE_INSERT, 32'h0000_0000);
        send_item(MODE_LOOKUP, 32'h0000_0000);
        send_item(MODE_INSERT, 32'h0000_0011);
        send_item(MODE_LOOKUP, 32'h0000_0100);
        send_item(MODE_INSERT, 32'h0000_0100);
        send_item(MODE_LOOKUP, 32'h0000_0100);
        send_item(MODE_INSERT, 32'h8080_8080);
        send_item(MODE_LOOKUP, 32'h0080_8080);
        send_item(MODE_LOOKUP, 32'h8080_8080);
        // same home slot as zero, different step
        send_item(MODE_INSERT, 32'h010B_050E);
        send_item(MODE_LOOKUP, 32'h010B_050E);
        send_item(MODE_INSERT, 32'h00FF_00FF);
        send_item(MODE_LOOKUP, 32'hFF00_FF00);
        send_item(MODE_LOOKUP, 32'h7FFF_FFFF);
        wait_drained();

        // random inserts and lookups, the lookups mostly of stored words
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (i == 350 || i == 1000)
            begin
                rsp_hold_long = 1'b1;
            end
            if (i == 700)
            begin
                wait_drained();
            end
            if (i == 1200)
            begin
                no_idle = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    w = $urandom;
                end
                else if (pick < 85)
                begin
                    w = inserted_q[$urandom_range(0, inserted_q.size() - 1)];
                end
                else
                begin
                    w = key_twin(inserted_q[$urandom_range(0, inserted_q.size() - 1)]);
                end
                send_item(MODE_INSERT, w);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    w = inserted_q[$urandom_range(0, inserted_q.size() - 1)];
                end
                else if (pick < 75)
                begin
                    w = key_twin(inserted_q[$urandom_range(0, inserted_q.size() - 1)]);
                end
                else
                begin
                    w = $urandom;
                end
                send_item(MODE_LOOKUP, w);
            end
        end
        wait_drained();
        repeat (50) @(posedge clk);

        if (mismatch_count == 0 && due_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            if (due_count != 0)
            begin
                $display("responses never received: %0d", due_count);
            end
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== double_hash_word_table_core.f =====
hw/rtl/dhwt_pkg.sv
hw/rtl/dhwt_front.sv
hw/rtl/dhwt_queue.sv
hw/rtl/dhwt_back.sv
hw/rtl/double_hash_word_table_core.sv
test/dhwt_checker.sv
test/tb.sv
